FILE: src/svalloc_pkg.sv
// Shared types and constants for the synth voice allocator.
// Transaction structs, the scan token passed along the voice chain and the commit bus.
// No dependencies.
`timescale 1ns / 1ps

package svalloc_pkg;

    localparam int SLOT_W = 4;
    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;
    localparam int SEED_W = 32;
    localparam int MASK_W = 16;
    localparam int ACT_W  = 2;

    // Input action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_NOTE_ON  = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_FINISH   = 2'd2
    } action_t;

    // Input transaction
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [NOTE_W-1:0] note_number;
        logic [VEL_W-1:0]  note_velocity;
        logic [SLOT_W-1:0] finished_voice;
    } event_item_t;

    // Output transaction
    typedef struct packed {
        logic [SLOT_W-1:0] voice_slot;
        logic              voice_started;
        logic              voice_stolen;
        logic [SEED_W-1:0] voice_seed;
        logic [MASK_W-1:0] released_mask;
    } result_item_t;

    // Operation carried by the token through the chain
    typedef enum logic [1:0] {
        OP_SCAN    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_FINISH  = 2'd2
    } tok_op_t;

    // Token moving one cell per cycle
    typedef struct packed {
        logic              valid;
        tok_op_t           op;
        logic [NOTE_W-1:0] note;
        logic [SLOT_W-1:0] fin;
        logic              found_free;
        logic [SLOT_W-1:0] free_slot;
        logic              found_rel;
        logic [SLOT_W-1:0] rel_slot;
        logic [MASK_W-1:0] mask;
    } tok_t;

    // Which flagged cell takes the new note
    typedef enum logic [1:0] {
        SEL_FREE = 2'd0,
        SEL_REL  = 2'd1,
        SEL_ZERO = 2'd2
    } sel_t;

    // Broadcast voice start after a scan completes
    typedef struct packed {
        logic              en;
        sel_t              sel;
        logic [NOTE_W-1:0] note;
    } commit_t;

endpackage

FILE: src/svalloc_cell.sv
// One voice cell of the allocator chain: holds active/released/note of a voice.
// Updates the passing token and registers it for the next cell.
// Depends on svalloc_pkg.
`timescale 1ns / 1ps

module svalloc_cell #(
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  svalloc_pkg::tok_t    tok_in,
    output svalloc_pkg::tok_t    tok_out,
    input  svalloc_pkg::commit_t commit
);
    import svalloc_pkg::*;

    localparam logic [SLOT_W-1:0] IDX_LO   = SLOT_W'(IDX);
    localparam bit                IN_MASK  = (IDX < MASK_W);
    localparam bit                IS_ZERO  = (IDX == 0);
    localparam logic [MASK_W-1:0] MASK_BIT = IN_MASK ? (MASK_W'(1) << IDX) : '0;

    logic              active_reg, active_next;
    logic              released_reg, released_next;
    logic [NOTE_W-1:0] note_reg, note_next;
    logic              pick_free_reg, pick_free_next;
    logic              pick_rel_reg, pick_rel_next;
    tok_t              tok_reg, tok_next;

    logic scan_here;
    logic free_first;
    logic rel_first;
    logic rel_hit;
    logic fin_hit;
    logic start_hit;

    // Token processing and local state update
    always_comb
    begin
        scan_here  = tok_in.valid && (tok_in.op == OP_SCAN);
        free_first = scan_here && !tok_in.found_free && !active_reg;
        rel_first  = scan_here && !tok_in.found_rel && active_reg && released_reg;
        rel_hit    = tok_in.valid && (tok_in.op == OP_RELEASE) && active_reg
                     && !released_reg && (note_reg == tok_in.note);
        fin_hit    = tok_in.valid && (tok_in.op == OP_FINISH) && IN_MASK
                     && (tok_in.fin == IDX_LO);
        start_hit  = commit.en && (((commit.sel == SEL_FREE) && pick_free_reg)
                     || ((commit.sel == SEL_REL) && pick_rel_reg)
                     || ((commit.sel == SEL_ZERO) && IS_ZERO));

        tok_next       = tok_in;
        active_next    = active_reg;
        released_next  = released_reg;
        note_next      = note_reg;
        pick_free_next = pick_free_reg;
        pick_rel_next  = pick_rel_reg;

        // scan: remember whether this cell is the first candidate of each kind
        if (scan_here)
        begin
            pick_free_next = free_first;
            pick_rel_next  = rel_first;
        end
        if (free_first)
        begin
            tok_next.found_free = 1'b1;
            tok_next.free_slot  = IDX_LO;
        end
        if (rel_first)
        begin
            tok_next.found_rel = 1'b1;
            tok_next.rel_slot  = IDX_LO;
        end

        // note off
        if (rel_hit)
        begin
            released_next = 1'b1;
            tok_next.mask = tok_in.mask | MASK_BIT;
        end

        // voice finished
        if (fin_hit)
        begin
            active_next   = 1'b0;
            released_next = 1'b0;
        end

        // voice start (never coincides with a token at this cell)
        if (start_hit)
        begin
            active_next   = 1'b1;
            released_next = 1'b0;
            note_next     = commit.note;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            released_reg  <= 1'b0;
            note_reg      <= '0;
            pick_free_reg <= 1'b0;
            pick_rel_reg  <= 1'b0;
            tok_reg       <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            released_reg  <= released_next;
            note_reg      <= note_next;
            pick_free_reg <= pick_free_next;
            pick_rel_reg  <= pick_rel_next;
            tok_reg       <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: src/synth_voice_allocator.sv
// Synth voice allocator top level: chain of NUM_VOICES voice cells plus control.
// Each event's token walks through every cell of the chain, one cell a cycle; its result is then registered
// and loaded into the output register. An ignored item skips the chain.
// One event at a time: event_stall stays high until the current result is loaded into the output register.
// A finished result waits in the output register while the next event is taken.
// Reset (rst_n, async low) clears all voices, the seed counter and program_valid.
// Depends on svalloc_pkg and svalloc_cell.
`timescale 1ns / 1ps

module synth_voice_allocator #(
    parameter int NUM_VOICES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // event channel
    input  logic                      event_valid,
    output logic                      event_stall,
    input  svalloc_pkg::event_item_t  event_item,
    // result channel
    output logic                      result_valid,
    input  logic                      result_stall,
    output svalloc_pkg::result_item_t result_item,
    // configuration write
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data
);
    import svalloc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic              program_valid_reg, program_valid_next;
    logic [SEED_W-1:0] seed_reg, seed_next;
    result_item_t      res_reg, res_next;
    result_item_t      out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    tok_t              tok_chain [NUM_VOICES+1];
    tok_t              tok_head;
    tok_t              tok_end;
    commit_t           commit;
    logic              accept;
    logic              is_note_on;

    // Voice chain
    for (genvar i = 0; i < NUM_VOICES; i++)
    begin : g_cell
        svalloc_cell #(
            .IDX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .tok_in (tok_chain[i]),
            .tok_out(tok_chain[i+1]),
            .commit (commit)
        );
    end

    assign tok_chain[0] = tok_head;
    assign tok_end      = tok_chain[NUM_VOICES];
    assign event_stall  = (state_reg != S_IDLE);
    assign accept       = event_valid && !event_stall;
    assign is_note_on   = (event_item.action == ACT_NOTE_ON) && (event_item.note_velocity != '0);
    assign cfg_ready    = 1'b1;

    // Token injection into the first cell
    always_comb
    begin
        tok_head      = '0;
        tok_head.note = event_item.note_number;
        tok_head.fin  = event_item.finished_voice;
        if (accept)
        begin
            unique case (action_t'(event_item.action))
                ACT_NOTE_ON:
                begin
                    tok_head.valid = is_note_on ? program_valid_reg : 1'b1;
                    tok_head.op    = is_note_on ? OP_SCAN : OP_RELEASE;
                end
                ACT_NOTE_OFF:
                begin
                    tok_head.valid = 1'b1;
                    tok_head.op    = OP_RELEASE;
                end
                ACT_FINISH:
                begin
                    tok_head.valid = 1'b1;
                    tok_head.op    = OP_FINISH;
                end
                default:
                begin
                    tok_head.valid = 1'b0;
                end
            endcase
        end
    end

    // Control, voice start and result assembly
    always_comb
    begin
        state_next         = state_reg;
        program_valid_next = program_valid_reg;
        seed_next          = seed_reg;
        res_next           = res_reg;
        out_next           = out_reg;
        out_valid_next     = out_valid_reg;
        commit             = '0;
        commit.note        = tok_end.note;

        if (cfg_valid && cfg_ready)
            program_valid_next = cfg_data;

        // output register drains
        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = tok_head.valid ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (tok_end.valid)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                    if (tok_end.op == OP_SCAN)
                    begin
                        commit.en              = 1'b1;
                        res_next.voice_started = 1'b1;
                        res_next.voice_stolen  = !tok_end.found_free;
                        res_next.voice_seed    = seed_reg;
                        seed_next              = seed_reg + SEED_W'(1);
                        priority if (tok_end.found_free)
                        begin
                            commit.sel          = SEL_FREE;
                            res_next.voice_slot = tok_end.free_slot;
                        end
                        else if (tok_end.found_rel)
                        begin
                            commit.sel          = SEL_REL;
                            res_next.voice_slot = tok_end.rel_slot;
                        end
                        else
                        begin
                            commit.sel          = SEL_ZERO;
                            res_next.voice_slot = '0;
                        end
                    end
                    else if (tok_end.op == OP_RELEASE)
                    begin
                        res_next.released_mask = tok_end.mask;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            program_valid_reg <= 1'b0;
            seed_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            program_valid_reg <= program_valid_next;
            seed_reg          <= seed_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

endmodule

FILE: dv/tb_synth_voice_allocator.sv
// Testbench for synth_voice_allocator: random and directed note events, scoreboarded
// against a voice allocation predictor kept in this file.
// Depends on svalloc_pkg and the synth_voice_allocator RTL.
`timescale 1ns / 1ps

module tb_synth_voice_allocator;

    import svalloc_pkg::*;

    localparam int VOICES = 16;
    // action code the block must ignore
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         event_valid = 1'b0;
    logic         event_stall;
    event_item_t  event_item = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data = 1'b0;

    // predicted voice state
    logic              voice_on [VOICES];
    logic              voice_rel [VOICES];
    logic [NOTE_W-1:0] voice_key [VOICES];
    logic [SEED_W-1:0] seed_next;
    logic              program_loaded;

    event_item_t  queued_events [$];
    result_item_t owed_results [$];
    int           errors = 0;
    int           results_seen = 0;

    synth_voice_allocator #(
        .NUM_VOICES(VOICES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_item   (event_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expected outcome of one event; updates the predicted voice state
    function automatic result_item_t predict_voice_event(event_item_t ev);
        result_item_t res;
        int pick;
        res = '0;
        if (ev.action == ACT_NOTE_ON && ev.note_velocity != '0)
        begin
            if (program_loaded)
            begin
                pick = -1;
                for (int i = 0; i < VOICES; i++)
                    if (pick < 0 && !voice_on[i])
                        pick = i;
                for (int i = 0; i < VOICES; i++)
                    if (pick < 0 && voice_on[i] && voice_rel[i])
                        pick = i;
                if (pick < 0)
                    pick = 0;
                res.voice_stolen  = voice_on[pick];
                res.voice_started = 1'b1;
                res.voice_slot    = 4'(pick);
                res.voice_seed    = seed_next;
                voice_on[pick]  = 1'b1;
                voice_rel[pick] = 1'b0;
                voice_key[pick] = ev.note_number;
                seed_next       = seed_next + 1;
            end
        end
        else if (ev.action == ACT_NOTE_ON || ev.action == ACT_NOTE_OFF)
        begin
            // release every held voice on this note
            for (int i = 0; i < VOICES; i++)
            begin
                if (voice_on[i] && !voice_rel[i] && voice_key[i] == ev.note_number)
                begin
                    voice_rel[i] = 1'b1;
                    if (i < MASK_W)
                        res.released_mask[i] = 1'b1;
                end
            end
        end
        else if (ev.action == ACT_FINISH)
        begin
            if (ev.finished_voice < VOICES)
            begin
                voice_on[ev.finished_voice]  = 1'b0;
                voice_rel[ev.finished_voice] = 1'b0;
            end
        end
        return res;
    endfunction

    // Mostly short idle gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, label, want, got);
            errors++;
        end
    endtask

    // Event driver: offers queued events, predicts each accepted transaction
    int send_gap = 0;
    int send_calm = 0;
    always @(posedge clk)
    begin : drive_events
        event_item_t next_item;
        logic        next_valid;
        next_item  = event_item;
        next_valid = event_valid;
        if (event_valid && !event_stall)
        begin
            owed_results.push_back(predict_voice_event(event_item));
            next_valid = 1'b0;
        end
        if (!next_valid && rst_n)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (queued_events.size() > 0)
            begin
                next_item  = queued_events.pop_front();
                next_valid = 1'b1;
                if (send_calm > 0)
                    send_calm--;
                else if ($urandom_range(0, 39) == 0)
                    send_calm = $urandom_range(20, 60);
                else
                    send_gap = pick_gap();
            end
        end
        event_valid <= next_valid;
        event_item  <= next_item;
    end

    // Result monitor: scoreboard check plus receiver stalls
    int hold_left = 0;
    int stall_left = 0;
    int calm_left = 0;
    int next_hold_at = 200;
    always @(posedge clk)
    begin : watch_results
        result_item_t want;
        logic         next_stall;
        next_stall = result_stall;
        if (result_valid && !result_stall)
        begin
            results_seen++;
            if (owed_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, got %0h", $time, result_item);
                errors++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("voice_slot", want.voice_slot, result_item.voice_slot);
                check_field("voice_started", want.voice_started, result_item.voice_started);
                check_field("voice_stolen", want.voice_stolen, result_item.voice_stolen);
                check_field("voice_seed", want.voice_seed, result_item.voice_seed);
                check_field("released_mask", want.released_mask, result_item.released_mask);
            end
        end
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (results_seen >= next_hold_at)
            begin
                // long hold-off so the block backs up and stalls its input
                hold_left    = 300;
                next_hold_at = next_hold_at + 600;
                next_stall   = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_stall = 1'b1;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                next_stall = 1'b0;
            end
            else
            begin
                calm_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(0, 12);
                stall_left = pick_gap();
                next_stall = 1'b0;
            end
        end
        result_stall <= next_stall;
    end

    task automatic push_event(logic [ACT_W-1:0] act, int note, int vel, int fin);
        event_item_t ev;
        ev.action         = act;
        ev.note_number    = NOTE_W'(note);
        ev.note_velocity  = VEL_W'(vel);
        ev.finished_voice = SLOT_W'(fin);
        queued_events.push_back(ev);
    endtask

    // Block until every queued event is sent and every result has come back
    task automatic wait_drained();
        @(negedge clk);
        while (queued_events.size() != 0 || event_valid || owed_results.size() != 0)
            @(negedge clk);
        repeat (VOICES + 4) @(negedge clk);
    endtask

    task automatic write_program_valid(logic value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        program_loaded = value;
        @(negedge clk);
    endtask

    // Random events: a small note pool keeps note-offs hitting held voices
    task automatic queue_random_events(int count, int on_pct);
        logic [NOTE_W-1:0] pool [8];
        event_item_t ev;
        int r;
        int rest;
        int span;
        for (int k = 0; k < 8; k++)
            pool[k] = NOTE_W'($urandom_range(0, 127));
        span = 100 - on_pct;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            ev.note_number    = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)]
                                                           : NOTE_W'($urandom_range(0, 127));
            ev.note_velocity  = VEL_W'($urandom_range(1, 127));
            ev.finished_voice = SLOT_W'($urandom_range(0, 15));
            if (r < on_pct)
            begin
                ev.action = ACT_NOTE_ON;
                if ($urandom_range(0, 19) == 0)
                    ev.note_velocity = '0;
            end
            else
            begin
                rest = r - on_pct;
                if (rest * 10 < span * 6)
                begin
                    ev.action        = ACT_NOTE_OFF;
                    ev.note_velocity = VEL_W'($urandom_range(0, 127));
                end
                else if (rest * 10 < span * 9)
                    ev.action = ACT_FINISH;
                else
                begin
                    // noise: any code, any field bits
                    ev.action        = ACT_W'($urandom_range(0, 3));
                    ev.note_velocity = VEL_W'($urandom_range(0, 127));
                end
            end
            queued_events.push_back(ev);
        end
    endtask

    // Stimulus sequence
    initial
    begin : run_test
        for (int i = 0; i < VOICES; i++)
        begin
            voice_on[i]  = 1'b0;
            voice_rel[i] = 1'b0;
            voice_key[i] = '0;
        end
        seed_next      = '0;
        program_loaded = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no program loaded: note-ons ignored
        push_event(ACT_NOTE_ON, 127, 127, 0);
        push_event(ACT_FINISH, 0, 0, 15);
        push_event(ACT_UNUSED, 127, 127, 15);
        push_event(ACT_NOTE_OFF, 0, 0, 0);
        wait_drained();

        write_program_valid(1'b1);
        // fill every voice; voices 1 and 2 share a note
        for (int i = 0; i < VOICES; i++)
            push_event(ACT_NOTE_ON, (i == 0) ? 127 : (i < 3) ? 60 : i * 7,
                       (i == 1) ? 1 : 127 - i, 0);
        push_event(ACT_NOTE_ON, 0, 64, 0);      // all held: steal voice 0
        push_event(ACT_NOTE_OFF, 60, 0, 0);     // releases two voices
        push_event(ACT_NOTE_ON, 85, 127, 0);    // takes first released voice
        push_event(ACT_NOTE_ON, 0, 0, 0);       // zero velocity releases voice 0
        push_event(ACT_FINISH, 0, 0, 15);
        push_event(ACT_FINISH, 0, 0, 15);       // already inactive
        push_event(ACT_NOTE_ON, 127, 127, 0);   // reuses the finished voice
        push_event(ACT_NOTE_OFF, 127, 127, 0);
        push_event(ACT_UNUSED, 127, 127, 15);
        wait_drained();

        queue_random_events(450, 50);
        wait_drained();
        write_program_valid(1'b0);
        queue_random_events(80, 50);
        wait_drained();
        write_program_valid(1'b1);
        queue_random_events(400, 70);
        wait_drained();
        write_program_valid(1'b0);
        queue_random_events(40, 50);
        wait_drained();
        write_program_valid(1'b1);
        queue_random_events(400, 40);
        wait_drained();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
